[design/sine_tone_generator_assert.svh]
// Assertion macros for the tone generator checks.
// Each macro expects a clock named clk in the scope where it is used.
`ifndef SINE_TONE_GENERATOR_ASSERT_SVH
`define SINE_TONE_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define STG_ASSERT_IMP(lbl, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STG_ASSERT_NXT(lbl, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/stg_pkg.sv]
`default_nettype none

package stg_pkg;

  // Default configuration
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_RATE_DEF = 16000;
  localparam int PHASE_FRAC_DEF  = 16;

  // Word field widths
  localparam int FREQ_W = 13;
  localparam int MS_W   = 16;
  localparam int VOL_W  = 16;
  localparam int SMP_W  = 16;
  localparam int AMP_W  = 15;

  localparam int FREQ_MAX_HZ   = 8000;
  localparam int GAIN_FULL     = 32768;
  localparam int GAIN_SHIFT    = 15;
  localparam int AMPLITUDE     = 32767;
  localparam int MS_PER_SECOND = 1000;

  // Request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam real TWO_PI = 6.28318530717958647692;

  // Sign and magnitude of one sine sample
  typedef struct packed {
    logic             neg;
    logic [AMP_W-1:0] mag;
  } sine_word_t;

  // First-quadrant table entry: trunc(32767 * sin(k * step_rad)),
  // step_rad being one table step in radians
  function automatic logic [AMP_W-1:0] qtab_entry(input int k, input real step_rad);
    real x;
    real v;
    int  n;
    x = step_rad * k;
    v = real'(AMPLITUDE) * $sin(x);
    n = $rtoi(v);
    if (n > AMPLITUDE) n = AMPLITUDE;
    if (n < 0) n = 0;
    return AMP_W'(n);
  endfunction

endpackage

`default_nettype wire

[design/stg_req_if.sv]
`default_nettype none

interface stg_req_if;
  import stg_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [FREQ_W-1:0] tone_freq_hz;
  logic [MS_W-1:0]   tone_ms;
  logic [VOL_W-1:0]  volume;

  modport source (
    output valid, req_type, tone_freq_hz, tone_ms, volume,
    input  ready
  );

  modport sink (
    input  valid, req_type, tone_freq_hz, tone_ms, volume,
    output ready
  );
endinterface

`default_nettype wire

[design/stg_smp_if.sv]
`default_nettype none

interface stg_smp_if;
  import stg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;
  logic                    last_sample;

  modport source (
    output valid, sample, last_sample,
    input  ready
  );

  modport sink (
    input  valid, sample, last_sample,
    output ready
  );
endinterface

`default_nettype wire

[design/stg_div.sv]
`default_nettype none

// Constant-ratio scaler: quotient = floor(dividend * NUM / DEN), by reciprocal
// multiplication. The whole part of NUM / DEN is a plain constant multiply; the
// fraction (NUM % DEN) / DEN carries enough bits to stay exact for any dividend.
module stg_div #(
  parameter int     X_W = 16,
  parameter int     Q_W = 20,
  parameter longint NUM = 16000,
  parameter int     DEN = 1000
) (
  input  wire logic [X_W-1:0] dividend,
  output logic [Q_W-1:0]      quotient
);

  localparam int     S   = X_W + $clog2(DEN);
  localparam int     PW  = X_W + S;
  localparam longint Q0  = NUM / longint'(DEN);
  localparam longint RMD = NUM % longint'(DEN);
  localparam longint KF  = ((RMD <<< S) + longint'(DEN) - 1) / longint'(DEN);
  localparam logic [Q_W-1:0] Q0_C = Q_W'(Q0);
  localparam logic [S-1:0]   KF_C = S'(KF);

  logic [Q_W-1:0] whole;
  logic [PW-1:0]  frac_prod;

  always_comb begin
    whole     = Q_W'(dividend) * Q0_C;
    frac_prod = PW'(dividend) * PW'(KF_C);
  end

  assign quotient = whole + Q_W'(frac_prod[PW-1:S]);

endmodule

`default_nettype wire

[design/stg_sine_lut.sv]
`default_nettype none

// Quarter-wave sine lookup with registered output.
module stg_sine_lut #(
  parameter int TABLE_DEPTH = stg_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] idx,
  output stg_pkg::sine_word_t                 word
);
  import stg_pkg::*;

  localparam int  L          = $clog2(TABLE_DEPTH);
  localparam int  QW         = L - 2;
  localparam int  Q          = TABLE_DEPTH / 4;
  localparam real PHASE_UNIT = TWO_PI / TABLE_DEPTH;

  logic [AMP_W-1:0] qtab [Q];

  for (genvar g = 0; g < Q; g++) begin : g_qtab
    localparam logic [AMP_W-1:0] ENT = qtab_entry(g, PHASE_UNIT);
    assign qtab[g] = ENT;
  end

  logic          half;
  logic          desc;
  logic [QW-1:0] k;
  logic [QW-1:0] addr;
  logic          peak;
  logic [AMP_W-1:0] mag;

  always_comb begin
    half = idx[L-1];
    desc = idx[L-2];
    k    = idx[QW-1:0];
    // second and fourth quadrants mirror the first
    addr = desc ? QW'(~k + QW'(1)) : k;
    peak = desc && (k == '0);
    mag  = peak ? AMP_W'(AMPLITUDE) : qtab[addr];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word.neg <= half;
      word.mag <= mag;
    end
  end

endmodule

`default_nettype wire

[design/sine_tone_generator.sv]
// A tick's sample passes the index, table and output registers. Throughput: one word
// per cycle unless an output word waits, starts and ticks alike; ticks while idle give
// no word. A start word is taken at once: step and sample count come from constant-ratio
// multipliers, so a tick may follow directly. Ready drops only in reset or while an output word waits.
// Reset (rst, synchronous, active high) clears phase, step, gain, sample count and all
// valid flags; the block comes out of reset idle.
`default_nettype none

module sine_tone_generator #(
  parameter int TABLE_DEPTH     = stg_pkg::TABLE_DEPTH_DEF,
  parameter int SAMPLE_RATE_HZ  = stg_pkg::SAMPLE_RATE_DEF,
  parameter int PHASE_FRAC_BITS = stg_pkg::PHASE_FRAC_DEF
) (
  input wire logic clk,
  input wire logic rst,
  stg_req_if.sink  req,
  stg_smp_if.source smp
);
  import stg_pkg::*;

  // Phase word: log2(TABLE_DEPTH) integer bits over PHASE_FRAC_BITS fraction bits.
  // TABLE_DEPTH is a power of two, so wrapping the phase is plain truncation.
  localparam int L          = $clog2(TABLE_DEPTH);
  localparam int PHW        = L + PHASE_FRAC_BITS;
  localparam longint MAX_CNT = (longint'(65535) * SAMPLE_RATE_HZ) / MS_PER_SECOND;
  localparam int CNT_W      = $clog2(MAX_CNT + 1);
  localparam int PROD_W     = AMP_W + VOL_W;

  // Tone state
  logic [PHW-1:0]   phase_acc;
  logic [PHW-1:0]   phase_step;
  logic [CNT_W-1:0] samples_left;
  logic [VOL_W-1:0] gain;

  // Sample pipeline
  logic             s1_valid;
  logic [L-1:0]     s1_idx;
  logic [VOL_W-1:0] s1_gain;
  logic             s1_last;
  logic             s2_valid;
  logic [VOL_W-1:0] s2_gain;
  logic             s2_last;
  sine_word_t       lut_word;
  logic             out_valid;
  logic [SMP_W-1:0] out_sample;
  logic             out_last;

  // Handshake and decode
  logic adv;        // whole pipeline moves when the output register is free
  logic req_fire;
  logic is_start;
  logic active;

  assign adv      = !out_valid || smp.ready;
  assign req.ready = !rst && adv;
  assign req_fire = req.valid && req.ready;
  assign is_start = (req.req_type == REQ_START);
  assign active   = (samples_left != '0);

  // Start word decode: saturate frequency and gain
  logic [FREQ_W-1:0] freq_sat;
  logic [VOL_W-1:0]  vol_sat;

  always_comb begin
    freq_sat = (req.tone_freq_hz > FREQ_W'(FREQ_MAX_HZ)) ? FREQ_W'(FREQ_MAX_HZ)
                                                          : req.tone_freq_hz;
    vol_sat  = (req.volume > VOL_W'(GAIN_FULL)) ? VOL_W'(GAIN_FULL) : req.volume;
  end

  logic             start_fire;
  logic [PHW-1:0]   step_q;
  logic [CNT_W-1:0] cnt_q;

  assign start_fire = req_fire && is_start;

  // phase step = freq * TABLE_DEPTH * 2^frac / SAMPLE_RATE_HZ;
  // TABLE_DEPTH * 2^frac is just 2^PHW
  stg_div #(
    .X_W (FREQ_W),
    .Q_W (PHW),
    .NUM (longint'(1) <<< PHW),
    .DEN (SAMPLE_RATE_HZ)
  ) u_step_div (
    .dividend (freq_sat),
    .quotient (step_q)
  );

  // sample count = ms * SAMPLE_RATE_HZ / 1000
  stg_div #(
    .X_W (MS_W),
    .Q_W (CNT_W),
    .NUM (longint'(SAMPLE_RATE_HZ)),
    .DEN (MS_PER_SECOND)
  ) u_cnt_div (
    .dividend (req.tone_ms),
    .quotient (cnt_q)
  );

  // Control and tone state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      phase_step   <= '0;
      samples_left <= '0;
      gain         <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (start_fire) begin
        // a new tone drops whatever was playing;
        // step of exactly one full turn truncates to zero, same phase either way
        phase_acc    <= '0;
        phase_step   <= step_q;
        samples_left <= cnt_q;
        gain         <= vol_sat;
      end else if (req_fire && active) begin
        samples_left <= samples_left - CNT_W'(1);
        phase_acc    <= phase_acc + phase_step;
      end
      if (adv) begin
        s1_valid  <= req_fire && !is_start && active;
        s2_valid  <= s1_valid;
        out_valid <= s2_valid;
      end
    end
  end

  // Pipeline payload; gain rides along so a restart never touches words in flight
  logic [PROD_W-1:0] prod;
  logic [AMP_W-1:0]  scaled;
  logic [SMP_W-1:0]  smp_val;

  always_comb begin
    prod    = PROD_W'(lut_word.mag) * PROD_W'(s2_gain);
    scaled  = prod[GAIN_SHIFT +: AMP_W];
    // magnitude was truncated, so the sign is applied last: toward zero
    smp_val = lut_word.neg ? SMP_W'(-{1'b0, scaled}) : SMP_W'({1'b0, scaled});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx     <= phase_acc[PHW-1 -: L];
      s1_gain    <= gain;
      s1_last    <= (samples_left == CNT_W'(1));
      s2_gain    <= s1_gain;
      s2_last    <= s1_last;
      out_sample <= smp_val;
      out_last   <= s2_last;
    end
  end

  stg_sine_lut #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_lut (
    .clk  (clk),
    .en   (adv),
    .idx  (s1_idx),
    .word (lut_word)
  );

  assign smp.valid       = out_valid;
  assign smp.sample      = out_sample;
  assign smp.last_sample = out_last;

endmodule

`default_nettype wire

[design/stg_checker.sv]
`default_nettype none
`include "sine_tone_generator_assert.svh"

module stg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        smp_valid,
  input wire logic        smp_ready,
  input wire logic [15:0] smp_sample,
  input wire logic        smp_last_sample
);
  import stg_pkg::*;

  logic smp_free;
  logic smp_stall;

  assign smp_free  = !smp_valid || smp_ready;
  assign smp_stall = smp_valid && !smp_ready;

  `STG_ASSERT_NXT(a_reset_clears_out, 1'b0, rst, !smp_valid, "output valid after reset")
  `STG_ASSERT_IMP(a_free_takes_in, rst, smp_free, req_ready, "ready low with output free")
  `STG_ASSERT_IMP(a_out_stall_blocks_in, rst, smp_stall, !req_ready, "input taken while output stalled")
  `STG_ASSERT_NXT(a_out_hold, rst, smp_stall,
    smp_valid && $stable(smp_sample) && $stable(smp_last_sample), "stalled output word changed")

endmodule

bind sine_tone_generator stg_checker u_stg_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .smp_valid       (smp.valid),
  .smp_ready       (smp.ready),
  .smp_sample      (smp.sample),
  .smp_last_sample (smp.last_sample)
);

`default_nettype wire
